// ----- hw/rtl/lrci_pkg.sv -----
// Shared types and constants for the left rectangle cubic integrator.
package lrci_pkg;

  localparam int unsigned MAX_INTERVALS = 65536;
  localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned REG_W = 24;
  localparam int unsigned MUL_W = 24;
  localparam int unsigned DIV_W = 25;
  localparam logic [62:0] SAT_Q48 = '1;
  localparam logic [MUL_W-1:0] REL_SCALE = MUL_W'(6553600);

  typedef enum logic [1:0] {
    REG_LOWER = 2'd0,
    REG_UPPER = 2'd1,
    REG_STEP  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NEG      = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_TOO_MANY = 3'd3,
    ST_ZERO     = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_DIV2, S_DIV1, S_SQ, S_CLO, S_CHI, S_ACC, S_ADD,
    S_PM0, S_PM1, S_PM2, S_PM3, S_PEND, S_DIFF,
    S_NM0, S_NM1, S_NM2, S_NM3, S_NCMP, S_RDIV, S_OUT
  } state_t;

endpackage

// ----- hw/rtl/lrci_if.sv -----
// Request and result channel interfaces.
interface lrci_req_if;
  logic valid;
  logic ready;
  logic run_request;
  modport source (output valid, output run_request, input ready);
  modport sink (input valid, input run_request, output ready);
endinterface

interface lrci_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [63:0] integral_value;
  logic [62:0]        absolute_error;
  logic [31:0]        relative_error_percent;
  modport source (output valid, output status, output integral_value,
                  output absolute_error, output relative_error_percent, input ready);
  modport sink (input valid, input status, input integral_value,
                input absolute_error, input relative_error_percent, output ready);
endinterface

// ----- hw/rtl/lrci_mul.sv -----
// Shared unsigned multiplier with registered product.
module lrci_mul
  import lrci_pkg::*;
(
  input  logic                 clk,
  input  logic [MUL_W-1:0]     a,
  input  logic [MUL_W-1:0]     b,
  output logic [2*MUL_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- hw/rtl/left_rectangle_cubic_integrator_top.sv -----
// Left rectangle integrator of f(x) = 2x^3 - x^2 + 4x + 5, with n1 and n2 the
// full and half step interval counts: each sample costs three passes through
// the one 24x24 multiplier plus an accumulate, the interval counts come from a
// bit-serial divider and the relative error from a 32-step restoring divide.
// A bad bound or step goes from the check straight to the output, too many
// intervals after the first divide. Ready is high only while idle; one
// finished result may wait in the output register meanwhile.
module left_rectangle_cubic_integrator_top
  import lrci_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [REG_W-1:0]  cfg_data,
  lrci_req_if.sink          req,
  lrci_res_if.source        res
);

  state_t state, state_next;

  logic signed [REG_W-1:0] lo_b, up_b, step;

  logic [DIV_W-1:0] dnum, dq;
  logic [DIV_W-2:0] drem;
  logic [4:0]       dcnt;
  logic [CNT_W-1:0] n1, idx;
  logic             pass;
  logic [DIV_W-1:0] x, stride;
  logic [47:0]      sq, plo;
  logic [51:0]      fval;
  logic [71:0]      acc;
  logic [95:0]      pr;
  logic [62:0]      full, half, diff;
  logic [63:0]      rd;
  logic [31:0]      nlo, rel;
  logic [5:0]       rcnt;
  status_t          st;

  logic [MUL_W-1:0]   ma, mb;
  logic [2*MUL_W-1:0] prod;

  logic [DIV_W-1:0]  dt;
  logic              dge;
  logic [DIV_W-1:0]  dquo;
  logic [71:0]       c72;
  logic [83:0]       shv;
  logic [62:0]       satv;
  logic [64:0]       rt;
  logic              rge;
  logic [DIV_W-1:0]  hext;
  logic              out_load;

  lrci_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(prod));

  assign hext = {1'b0, step};
  assign dt   = {drem, dnum[DIV_W-1]};
  assign dge  = dt >= hext;
  assign dquo = {dq[DIV_W-2:0], dge};
  assign c72  = {prod, 24'b0} + {24'b0, plo};
  assign shv  = pass ? {1'b0, pr[95:13]} : pr[95:12];
  assign satv = (|shv[83:63]) ? SAT_Q48 : shv[62:0];
  assign rt   = {rd, nlo[31]};
  assign rge  = rt >= {2'b0, half};
  assign out_load = (state == S_OUT) && (!res.valid || res.ready);

  assign req.ready = (state == S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lo_b <= -24'sd40960;
      up_b <= 24'sd40960;
      step <= 24'sd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOWER: lo_b <= cfg_data;
        REG_UPPER: up_b <= cfg_data;
        REG_STEP:  step <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_SQ:  begin ma = x[MUL_W-1:0]; mb = x[MUL_W-1:0]; end
      S_CLO: begin ma = prod[23:0];  mb = x[MUL_W-1:0]; end
      S_CHI: begin ma = sq[47:24];   mb = x[MUL_W-1:0]; end
      S_PM0: begin ma = acc[23:0];   mb = step; end
      S_PM1: begin ma = acc[47:24];  mb = step; end
      S_PM2: begin ma = acc[71:48];  mb = step; end
      S_NM0: begin ma = diff[23:0];  mb = REL_SCALE; end
      S_NM1: begin ma = diff[47:24]; mb = REL_SCALE; end
      S_NM2: begin ma = {9'b0, diff[62:48]}; mb = REL_SCALE; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req.valid && req.run_request) state_next = S_CHK;
      S_CHK: begin
        if (lo_b < 0 || up_b < 0 || step <= 0 || up_b <= lo_b) state_next = S_OUT;
        else state_next = S_DIV2;
      end
      S_DIV2: begin
        if (dcnt == '0) state_next = (dquo > DIV_W'(MAX_INTERVALS)) ? S_OUT : S_DIV1;
      end
      S_DIV1: if (dcnt == '0) state_next = S_SQ;
      S_SQ:  state_next = S_CLO;
      S_CLO: state_next = S_CHI;
      S_CHI: state_next = S_ACC;
      S_ACC: state_next = S_ADD;
      S_ADD: state_next = (idx == CNT_W'(1)) ? S_PM0 : S_SQ;
      S_PM0: state_next = S_PM1;
      S_PM1: state_next = S_PM2;
      S_PM2: state_next = S_PM3;
      S_PM3: state_next = S_PEND;
      S_PEND: state_next = pass ? S_DIFF : S_SQ;
      S_DIFF: state_next = (half == '0) ? S_OUT : S_NM0;
      S_NM0: state_next = S_NM1;
      S_NM1: state_next = S_NM2;
      S_NM2: state_next = S_NM3;
      S_NM3: state_next = S_NCMP;
      S_NCMP: state_next = (pr >= {1'b0, half, 32'b0}) ? S_OUT : S_RDIV;
      S_RDIV: if (rcnt == 6'd1) state_next = S_OUT;
      S_OUT: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_CHK: begin
        st   <= ST_OK;
        half <= '0;
        diff <= '0;
        rel  <= '0;
        pass <= 1'b0;
        if (lo_b < 0 || up_b < 0) st <= ST_NEG;
        else if (step <= 0 || up_b <= lo_b) st <= ST_EMPTY;
        // n2 = ceil(2*span / h)
        dnum <= DIV_W'({1'b0, up_b - lo_b, 1'b0}) + DIV_W'(step) - DIV_W'(1);
        drem <= '0;
        dq   <= '0;
        dcnt <= 5'(DIV_W - 1);
      end
      S_DIV2, S_DIV1: begin
        dnum <= {dnum[DIV_W-2:0], 1'b0};
        drem <= dge ? (DIV_W-1)'(dt - hext) : dt[DIV_W-2:0];
        dq   <= {dq[DIV_W-2:0], dge};
        dcnt <= dcnt - 5'd1;
        if (dcnt == '0 && state == S_DIV2) begin
          if (dquo > DIV_W'(MAX_INTERVALS)) begin
            st <= ST_TOO_MANY;
          end
          // n1 = ceil(span / h)
          idx  <= CNT_W'(dquo);
          dnum <= DIV_W'(up_b - lo_b) + DIV_W'(step) - DIV_W'(1);
          drem <= '0;
          dq   <= '0;
          dcnt <= 5'(DIV_W - 1);
        end
        if (state == S_DIV1) begin
          if (dcnt == '0) begin
            n1     <= idx;
            idx    <= CNT_W'(dquo);
            x      <= {lo_b, 1'b0};
            stride <= {step, 1'b0};
            acc    <= '0;
          end
        end
      end
      S_CLO: sq <= prod;
      S_CHI: plo <= prod;
      S_ACC: fval <= {2'b0, c72[71:22]} + {23'b0, x[MUL_W-1:0], 5'b0}
                     + 52'd327680 - {14'b0, sq[47:10]};
      S_ADD: begin
        acc <= acc + {20'b0, fval};
        x   <= x + stride;
        idx <= idx - CNT_W'(1);
      end
      S_PM1, S_NM1: pr <= {48'b0, prod};
      S_PM2, S_NM2: pr <= pr + {24'b0, prod, 24'b0};
      S_PM3, S_NM3: pr <= pr + {prod, 48'b0};
      S_PEND: begin
        if (pass) begin
          half <= satv;
        end else begin
          full   <= satv;
          pass   <= 1'b1;
          x      <= {lo_b, 1'b0};
          stride <= {1'b0, step};
          acc    <= '0;
          // half-step count has waited in n1
          idx    <= n1;
        end
      end
      S_DIFF: begin
        diff <= (half >= full) ? half - full : full - half;
        if (half == '0) begin
          st  <= ST_ZERO;
          rel <= (half != full) ? '1 : '0;
        end
      end
      S_NCMP: begin
        rel  <= '1;
        rd   <= pr[95:32];
        nlo  <= pr[31:0];
        rcnt <= 6'd32;
      end
      S_RDIV: begin
        rd   <= rge ? 64'(rt - {2'b0, half}) : rt[63:0];
        nlo  <= {nlo[30:0], 1'b0};
        rel  <= {rel[30:0], rge};
        rcnt <= rcnt - 6'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.status                 <= st;
      res.integral_value         <= {1'b0, half};
      res.absolute_error         <= diff;
      res.relative_error_percent <= rel;
    end
  end

endmodule

// ----- bench/lrci_checker.sv -----
// Checker: follows the config port, predicts each run and compares the results.
module lrci_checker
  import lrci_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  lrci_req_if              req,
  lrci_res_if              res,
  output int unsigned      outstanding,
  output int unsigned      fails
);

  typedef struct packed {
    status_t            status;
    logic signed [63:0] integral_value;
    logic [62:0]        absolute_error;
    logic [31:0]        relative_error_percent;
  } run_result_t;

  logic signed [REG_W-1:0] lo_bound, hi_bound, step;
  run_result_t             expected_q[$];

  assign outstanding = expected_q.size();

  // f(x) in Q.16 for x in Q.13 units
  function automatic logic [127:0] cubic_q16(input logic [127:0] x);
    return ((x * x * x) >> 22) - ((x * x) >> 10) + (x << 5) + (128'd5 << 16);
  endfunction

  function automatic logic [127:0] sat_q48(input logic [127:0] v);
    return (v > {65'd0, SAT_Q48}) ? {65'd0, SAT_Q48} : v;
  endfunction

  function automatic run_result_t integrate_cubic(input logic signed [REG_W-1:0] a,
                                                  input logic signed [REG_W-1:0] b,
                                                  input logic signed [REG_W-1:0] h);
    run_result_t  r;
    logic [127:0] span, hu, n1, n2, start, acc, full, half, diff, num;
    r = '0;
    r.status = ST_OK;
    if (a < 0 || b < 0) begin
      r.status = ST_NEG;
      return r;
    end
    if (h <= 0 || b <= a) begin
      r.status = ST_EMPTY;
      return r;
    end
    span  = 128'(b) - 128'(a);
    hu    = 128'(h);
    n1    = (span + hu - 1) / hu;
    n2    = (2 * span + hu - 1) / hu;
    if (n2 > MAX_INTERVALS) begin
      r.status = ST_TOO_MANY;
      return r;
    end
    start = 2 * 128'(a);
    acc = '0;
    for (longint i = 0; i < longint'(n1); i++) acc += cubic_q16(start + 128'(i) * 2 * hu);
    full = sat_q48((acc * hu) >> 12);
    acc = '0;
    for (longint i = 0; i < longint'(n2); i++) acc += cubic_q16(start + 128'(i) * hu);
    half = sat_q48((acc * hu) >> 13);
    diff = (half >= full) ? half - full : full - half;
    r.integral_value = half[63:0];
    r.absolute_error = diff[62:0];
    if (half == 0) begin
      r.status = ST_ZERO;
      r.relative_error_percent = (diff != 0) ? '1 : '0;
    end else begin
      num = diff * 128'(REL_SCALE);
      if (num >= (half << 32)) r.relative_error_percent = '1;
      else r.relative_error_percent = 32'(num / half);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    run_result_t want;
    if (rst) begin
      lo_bound <= -24'sd40960;
      hi_bound <= 24'sd40960;
      step     <= 24'sd4096;
      fails    <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOWER: lo_bound <= cfg_data;
          REG_UPPER: hi_bound <= cfg_data;
          REG_STEP:  step     <= cfg_data;
          default: ;
        endcase
      end
      if (req.valid && req.ready && req.run_request)
        expected_q.push_back(integrate_cubic(lo_bound, hi_bound, step));
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected: status %0d", $time, res.status);
          fails <= fails + 1;
        end else begin
          want = expected_q.pop_front();
          if (res.status !== want.status ||
              res.integral_value !== want.integral_value ||
              res.absolute_error !== want.absolute_error ||
              res.relative_error_percent !== want.relative_error_percent) begin
            $display("%0t: expected status %0d integral %0d abs %0d rel %0d", $time,
                     want.status, want.integral_value, want.absolute_error,
                     want.relative_error_percent);
            $display("%0t: actual   status %0d integral %0d abs %0d rel %0d", $time,
                     res.status, res.integral_value, res.absolute_error,
                     res.relative_error_percent);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

// ----- bench/tb_left_rectangle_cubic_integrator_top.sv -----
// Testbench top: stimulus, idling and verdict for the cubic integrator.
module tb_left_rectangle_cubic_integrator_top;
  import lrci_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned SETTLE = 200;
  localparam int          BMAX = 8388607;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [REG_W-1:0] cfg_data;
  int unsigned      outstanding, fails, cycles;
  int unsigned      send_idle, recv_idle;

  lrci_req_if req();
  lrci_res_if res();

  left_rectangle_cubic_integrator_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req), .res(res)
  );

  lrci_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req), .res(res),
    .outstanding(outstanding), .fails(fails)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    res.ready <= ($urandom_range(99) >= recv_idle);
    if (cycles > CYCLE_LIMIT) begin
      $display("left_rectangle_cubic_integrator_top: mismatch");
      $finish;
    end
  end

  task automatic send_item(input logic rr);
    if ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.run_request <= rr;
    do @(posedge clk); while (!req.ready);
  endtask

  // lower valid and let the block go quiet
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(input int a, input int b, input int h);
    drain();
    cfg_we <= 1'b1; cfg_index <= REG_LOWER; cfg_data <= a[23:0];
    @(posedge clk);
    cfg_index <= REG_UPPER; cfg_data <= b[23:0];
    @(posedge clk);
    cfg_index <= REG_STEP; cfg_data <= h[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random setting: mostly valid with few intervals, some raw noise
  task automatic random_regs();
    int a, b, h, span;
    longint n2;
    if ($urandom_range(99) < 20) begin
      a = int'($urandom_range(24'hFFFFFF)) - ($urandom_range(1) ? 0 : 24'h800000);
      b = int'($urandom_range(24'hFFFFFF)) - ($urandom_range(1) ? 0 : 24'h800000);
      a = int'(signed'(a[23:0]));
      b = int'(signed'(b[23:0]));
      h = int'(signed'(24'($urandom)));
      if (a >= 0 && b > a && h > 0) begin
        n2 = (2 * longint'(b - a) + h - 1) / h;
        if (n2 > 64 && n2 <= MAX_INTERVALS) h = 0;
      end
    end else begin
      a = $urandom_range(BMAX - 1);
      h = $urandom_range(1, BMAX);
      span = $urandom_range(1, (longint'(h) * 32 < BMAX - a) ? h * 32 : BMAX - a);
      b = a + span;
    end
    set_regs(a, b, h);
  endtask

  initial begin
    send_idle = 0;
    recv_idle = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_LOWER;
    cfg_data <= '0;
    req.valid <= 1'b0;
    req.run_request <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting has a negative lower bound
    send_item(1'b1);
    send_item(1'b0);
    set_regs(0, 4096, 4096);              send_item(1'b1);
    set_regs(0, BMAX, BMAX);              send_item(1'b1);
    set_regs(BMAX - 1, BMAX, 1);          send_item(1'b1);
    set_regs(0, -1, 4096);                send_item(1'b1);
    set_regs(-8388608, BMAX, 4096);       send_item(1'b1);
    set_regs(100, 100, 4096);             send_item(1'b1);
    set_regs(200, 100, 4096);             send_item(1'b1);
    set_regs(0, 4096, 0);                 send_item(1'b1);
    set_regs(0, 4096, -1);                send_item(1'b1);
    set_regs(0, 4096, -8388608);          send_item(1'b1);
    // two intervals beyond the interval limit, then exactly at it
    set_regs(0, 32769, 1);                send_item(1'b1);
    set_regs(0, 32768, 1);                send_item(1'b1);
    set_regs(0, 3, 2);                    send_item(1'b1); send_item(1'b0);
    send_item(1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 16 : (phase == 1) ? 69 : 0;
      recv_idle = (phase == 0) ? 69 : (phase == 1) ? 16 : 0;
      for (int g = 0; g < 7; g++) begin
        random_regs();
        repeat ($urandom_range(3, 6)) send_item($urandom_range(99) < 85);
      end
    end

    drain();
    if (fails == 0 && outstanding == 0) begin
      $display("left_rectangle_cubic_integrator_top: match");
    end else begin
      $display("left_rectangle_cubic_integrator_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lrci_pkg.sv
hw/rtl/lrci_if.sv
hw/rtl/lrci_mul.sv
hw/rtl/left_rectangle_cubic_integrator_top.sv
bench/lrci_checker.sv
bench/tb_left_rectangle_cubic_integrator_top.sv
